[hw/rtl/qhsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qhsp_pkg
// Shared constants, types and the half-step coil table for the quad stepper
// positioner.
// ----------------------------------------------------------------------------
package qhsp_pkg;

   localparam int MOTOR_COUNT = 4;
   localparam int POS_W       = 16;
   localparam int PHASE_W     = 3;
   localparam int HOLD_W      = 8;
   localparam int COIL_W      = 4;

   localparam logic [POS_W-1:0]  HOME_POSITION = 16'd1200;
   localparam logic [HOLD_W-1:0] EXCITE_RESET  = 8'd5;

   typedef struct packed {
      logic [COIL_W-1:0] coils;
      logic [POS_W-1:0]  position;
      logic              moving;
   } lane_out_type;

   // Half-step drive: each coil is on for three consecutive phases.
   function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] p);
      logic [COIL_W-1:0] c;
      c = '0;
      if (p inside {3'd7, 3'd0, 3'd1}) c[0] = 1'b1;
      if (p inside {3'd1, 3'd2, 3'd3}) c[1] = 1'b1;
      if (p inside {3'd3, 3'd4, 3'd5}) c[2] = 1'b1;
      if (p inside {3'd5, 3'd6, 3'd7}) c[3] = 1'b1;
      return c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/qhsp_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qhsp_lane
// One motor: position, phase and hold counters, updated once per item.
// ----------------------------------------------------------------------------
module qhsp_lane
   import qhsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [POS_W-1:0]  target,
   input  wire logic [HOLD_W-1:0] hold_ticks,
   output lane_out_type           lane_out
);

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [HOLD_W-1:0]  up_ff,    up_in;
   logic [HOLD_W-1:0]  dn_ff,    dn_in;
   logic               at_target;
   logic               going_up;

   assign at_target = (pos_ff == target);
   assign going_up  = (pos_ff < target);

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      up_in    = up_ff;
      dn_in    = dn_ff;
      if (at_target) begin
         up_in = '0;
         dn_in = '0;
      end else if (going_up) begin
         dn_in = '0;
         if (up_ff < hold_ticks) begin
            up_in = up_ff + 8'd1;
         end else begin
            pos_in   = pos_ff + 16'd1;
            phase_in = phase_ff + 3'd1;
         end
      end else begin
         up_in = '0;
         if (dn_ff < hold_ticks) begin
            dn_in = dn_ff + 8'd1;
         end else begin
            pos_in   = pos_ff - 16'd1;
            phase_in = phase_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= HOME_POSITION;
         phase_ff <= '0;
         up_ff    <= '0;
         dn_ff    <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         up_ff    <= up_in;
         dn_ff    <= dn_in;
      end
   end

   // coils follow the phase after this tick; off when parked
   assign lane_out.coils    = at_target ? '0 : coil_pattern(phase_in);
   assign lane_out.position = pos_in;
   assign lane_out.moving   = !at_target;

endmodule
`default_nettype wire

[hw/rtl/qhsp_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qhsp_merge
// Combines the four lane results into one item and holds it in the output
// register until the consumer takes it.
// ----------------------------------------------------------------------------
module qhsp_merge
   import qhsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire lane_out_type lane_out [MOTOR_COUNT],
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [COIL_W-1:0] coils    [MOTOR_COUNT],
   output logic [POS_W-1:0]  position [MOTOR_COUNT],
   output logic              all_stopped
);

   logic              valid_ff, valid_in;
   logic [COIL_W-1:0] coils_ff [MOTOR_COUNT];
   logic [POS_W-1:0]  pos_ff   [MOTOR_COUNT];
   logic              stop_ff,  stop_in;
   logic              accept;

   // output register frees up in the same cycle it is drained
   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stop_in = 1'b1;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         if (lane_out[m].moving) stop_in = 1'b0;
      end
      valid_in = accept || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stop_ff <= stop_in;
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            coils_ff[m] <= lane_out[m].coils;
            pos_ff[m]   <= lane_out[m].position;
         end
      end
   end

   assign rsp_valid   = valid_ff;
   assign coils       = coils_ff;
   assign position    = pos_ff;
   assign all_stopped = stop_ff;

endmodule
`default_nettype wire

[hw/rtl/quad_half_step_stepper_positioner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quad_half_step_stepper_positioner
// Four half-step stepper motors driven toward per-tick target positions.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------
//  req     | req_target_0..3                | req_valid / req_stall
//  rsp     | rsp_coils_*, rsp_position_*,   | rsp_valid / rsp_stall
//          | rsp_all_stopped                |
//  csr     | csr_data (hold_ticks)          | csr_valid / csr_ready
//
//  One item per cycle unless stalled; the result appears in the cycle after
//  acceptance, set by the single output register behind the four motor lanes.
//  Reset is synchronous: positions return to 1200, phases and hold counters
//  clear, hold_ticks returns to 5.
//  req_stall rises only while a result waits and rsp_stall is high.
// ----------------------------------------------------------------------------
module quad_half_step_stepper_positioner
   import qhsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [POS_W-1:0]  req_target_0,
   input  wire logic [POS_W-1:0]  req_target_1,
   input  wire logic [POS_W-1:0]  req_target_2,
   input  wire logic [POS_W-1:0]  req_target_3,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [COIL_W-1:0]      rsp_coils_0,
   output logic [COIL_W-1:0]      rsp_coils_1,
   output logic [COIL_W-1:0]      rsp_coils_2,
   output logic [COIL_W-1:0]      rsp_coils_3,
   output logic [POS_W-1:0]       rsp_position_0,
   output logic [POS_W-1:0]       rsp_position_1,
   output logic [POS_W-1:0]       rsp_position_2,
   output logic [POS_W-1:0]       rsp_position_3,
   output logic                   rsp_all_stopped,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [HOLD_W-1:0] csr_data
);

   logic [HOLD_W-1:0] excite_ff;
   logic              accept;
   logic [POS_W-1:0]  target   [MOTOR_COUNT];
   lane_out_type      lane_out [MOTOR_COUNT];
   logic [COIL_W-1:0] coils    [MOTOR_COUNT];
   logic [POS_W-1:0]  position [MOTOR_COUNT];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         excite_ff <= EXCITE_RESET;
      end else if (csr_valid && csr_ready) begin
         excite_ff <= csr_data;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign target[0] = req_target_0;
   assign target[1] = req_target_1;
   assign target[2] = req_target_2;
   assign target[3] = req_target_3;

   for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
      qhsp_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .target     (target[m]),
         .hold_ticks (excite_ff),
         .lane_out   (lane_out[m])
      );
   end

   qhsp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .lane_out    (lane_out),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .coils       (coils),
      .position    (position),
      .all_stopped (rsp_all_stopped)
   );

   assign rsp_coils_0    = coils[0];
   assign rsp_coils_1    = coils[1];
   assign rsp_coils_2    = coils[2];
   assign rsp_coils_3    = coils[3];
   assign rsp_position_0 = position[0];
   assign rsp_position_1 = position[1];
   assign rsp_position_2 = position[2];
   assign rsp_position_3 = position[3];

endmodule
`default_nettype wire

[hw/rtl/qhsp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qhsp_checker
// Port-level checks on the positioner's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module qhsp_checker
   import qhsp_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [POS_W-1:0] rsp_position_0
);

   // every accepted item shows up on the next cycle
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // input backs up only while a result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a held result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position_0))
      else $error("stalled result dropped or changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind quad_half_step_stepper_positioner qhsp_checker u_qhsp_checker (.*);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - quad half-step stepper positioner
// Drives per-tick target sets into the block and checks every result against
// a local model of the four motor lanes (position, phase, hold counters).
// A short directed table comes first. Random target runs follow, with the
// excite hold time set per segment, random idling both sides before the last phase.
// ----------------------------------------------------------------------------
module tb;
   import qhsp_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 3;
   localparam int SEGMENTS     = 6;
   localparam int SEG_ITEMS    = 93;
   localparam int NO_WRITE     = -1;

   // Coil drive per half-step phase, coil 0 in bit 0.
   localparam logic [COIL_W-1:0] HALF_STEP_COILS [8] = '{
      4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001
   };

   typedef logic [MOTOR_COUNT-1:0][POS_W-1:0] target_set_type;

   typedef struct packed {
      logic [MOTOR_COUNT-1:0][COIL_W-1:0] coils;
      logic [MOTOR_COUNT-1:0][POS_W-1:0]  position;
      logic                               all_stopped;
   } tick_result_type;

   typedef struct packed {
      int              csr_value;       // hold ticks written first, NO_WRITE keeps it
      int              repeats;
      bit              track_position;  // targets follow the current positions
      bit              pinned;          // result typed in below
      target_set_type  targets;         // motor 3 .. motor 0
      tick_result_type result;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [10] = '{
      // home position, nothing moves
      '{csr_value: NO_WRITE, repeats: 1, track_position: 1'b0, pinned: 1'b1,
        targets: {4{HOME_POSITION}},
        result: '{coils: '0, position: {4{HOME_POSITION}}, all_stopped: 1'b1}},
      // first tick of a move up holds at phase 0
      '{csr_value: NO_WRITE, repeats: 1, track_position: 1'b0, pinned: 1'b1,
        targets: {HOME_POSITION, HOME_POSITION, HOME_POSITION, 16'd1201},
        result: '{coils: 16'h0001, position: {4{HOME_POSITION}}, all_stopped: 1'b0}},
      // no hold: step every tick, phase wraps both ways
      '{csr_value: 0, repeats: 10, track_position: 1'b0, pinned: 1'b0,
        targets: {16'hFFFF, 16'h0000, 16'd1180, 16'd1220}, result: '0},
      '{csr_value: NO_WRITE, repeats: 1, track_position: 1'b1, pinned: 1'b0,
        targets: '0, result: '0},
      // longest hold
      '{csr_value: 255, repeats: 3, track_position: 1'b0, pinned: 1'b0,
        targets: {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, result: '0},
      // direction change on motors 0 and 1
      '{csr_value: NO_WRITE, repeats: 2, track_position: 1'b0, pinned: 1'b0,
        targets: {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000}, result: '0},
      // hold time lowered below the running counters
      '{csr_value: 1, repeats: 2, track_position: 1'b0, pinned: 1'b0,
        targets: {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000}, result: '0},
      '{csr_value: NO_WRITE, repeats: 1, track_position: 1'b0, pinned: 1'b0,
        targets: {16'hFF00, 16'h00FF, 16'hAAAA, 16'h5555}, result: '0},
      '{csr_value: NO_WRITE, repeats: 1, track_position: 1'b0, pinned: 1'b0,
        targets: {16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA}, result: '0},
      '{csr_value: 5, repeats: 1, track_position: 1'b1, pinned: 1'b0,
        targets: '0, result: '0}
   };

   logic              clock;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   target_set_type    req_targets  = {4{HOME_POSITION}};
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   logic [COIL_W-1:0] rsp_coils_0, rsp_coils_1, rsp_coils_2, rsp_coils_3;
   logic [POS_W-1:0]  rsp_position_0, rsp_position_1, rsp_position_2, rsp_position_3;
   logic              rsp_all_stopped;
   logic              csr_valid    = 1'b0;
   logic              csr_ready;
   logic [HOLD_W-1:0] csr_data     = '0;

   // Typed-in result that rides along with the item on the request port.
   bit                req_pinned   = 1'b0;
   tick_result_type   req_pinned_result = '0;

   int sender_idle_pct   = 34;
   int receiver_stall_pct = 88;
   int error_count       = 0;
   int checked_ticks     = 0;
   int quiet_cycles      = 0;

   // Motor model state
   logic [MOTOR_COUNT-1:0][POS_W-1:0]   motor_pos;
   logic [MOTOR_COUNT-1:0][PHASE_W-1:0] motor_phase;
   logic [MOTOR_COUNT-1:0][HOLD_W-1:0]  up_hold, down_hold;
   logic [HOLD_W-1:0]                   hold_ticks;

   tick_result_type pending_ticks [$];

   quad_half_step_stepper_positioner i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_target_0    (req_targets[0]),
      .req_target_1    (req_targets[1]),
      .req_target_2    (req_targets[2]),
      .req_target_3    (req_targets[3]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coils_0     (rsp_coils_0),
      .rsp_coils_1     (rsp_coils_1),
      .rsp_coils_2     (rsp_coils_2),
      .rsp_coils_3     (rsp_coils_3),
      .rsp_position_0  (rsp_position_0),
      .rsp_position_1  (rsp_position_1),
      .rsp_position_2  (rsp_position_2),
      .rsp_position_3  (rsp_position_3),
      .rsp_all_stopped (rsp_all_stopped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic tick_result_type advance_motors(input target_set_type tgt);
      tick_result_type r;
      r = '0;
      r.all_stopped = 1'b1;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         if (motor_pos[m] == tgt[m]) begin
            up_hold[m]   = '0;
            down_hold[m] = '0;
         end else begin
            r.all_stopped = 1'b0;
            if (motor_pos[m] < tgt[m]) begin
               down_hold[m] = '0;
               if (up_hold[m] < hold_ticks) begin
                  up_hold[m] = up_hold[m] + 8'd1;
               end else begin
                  motor_pos[m]   = motor_pos[m] + 16'd1;
                  motor_phase[m] = motor_phase[m] + 3'd1;
               end
            end else begin
               up_hold[m] = '0;
               if (down_hold[m] < hold_ticks) begin
                  down_hold[m] = down_hold[m] + 8'd1;
               end else begin
                  motor_pos[m]   = motor_pos[m] - 16'd1;
                  motor_phase[m] = motor_phase[m] - 3'd1;
               end
            end
            r.coils[m] = HALF_STEP_COILS[motor_phase[m]];
         end
         r.position[m] = motor_pos[m];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH tick %0d: %s", $realtime, checked_ticks, msg);
      error_count++;
   endtask

   // Receiver stall, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin : monitor
      tick_result_type want, got;
      bit fired;
      fired = 1'b0;
      if (reset) begin
         motor_pos    = {MOTOR_COUNT{HOME_POSITION}};
         motor_phase  = '0;
         up_hold      = '0;
         down_hold    = '0;
         hold_ticks   = EXCITE_RESET;
         pending_ticks.delete();
         quiet_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            hold_ticks = csr_data;
            fired = 1'b1;
         end
         if (req_valid && !req_stall) begin
            want = advance_motors(req_targets);
            pending_ticks.push_back(req_pinned ? req_pinned_result : want);
            fired = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            fired = 1'b1;
            got.coils       = {rsp_coils_3, rsp_coils_2, rsp_coils_1, rsp_coils_0};
            got.position    = {rsp_position_3, rsp_position_2,
                               rsp_position_1, rsp_position_0};
            got.all_stopped = rsp_all_stopped;
            if (pending_ticks.size() == 0) begin
               report_mismatch("result with no tick pending");
            end else begin
               want = pending_ticks.pop_front();
               for (int m = 0; m < MOTOR_COUNT; m++) begin
                  if (got.coils[m] !== want.coils[m])
                     report_mismatch($sformatf("coils_%0d expected %b got %b",
                                     m, want.coils[m], got.coils[m]));
                  if (got.position[m] !== want.position[m])
                     report_mismatch($sformatf("position_%0d expected %0d got %0d",
                                     m, want.position[m], got.position[m]));
               end
               if (got.all_stopped !== want.all_stopped)
                  report_mismatch($sformatf("all_stopped expected %b got %b",
                                  want.all_stopped, got.all_stopped));
            end
            checked_ticks++;
         end
         quiet_cycles <= fired ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Called at a falling edge with the previous item already taken; returns at
   // the falling edge after this one is taken, valid still high.
   task automatic send_tick(input target_set_type tgt, input bit pin,
                            input tick_result_type pin_result);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_targets       = tgt;
      req_pinned        = pin;
      req_pinned_result = pin_result;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_valid = 1'b0;
      while (pending_ticks.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_hold_ticks(input logic [HOLD_W-1:0] value);
      wait_for_idle();
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      target_set_type goal, tgt;
      int r, v;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].csr_value != NO_WRITE)
            set_hold_ticks(HOLD_W'(DIRECTED_ROWS[i].csr_value));
         repeat (DIRECTED_ROWS[i].repeats) begin
            tgt = DIRECTED_ROWS[i].track_position ? motor_pos : DIRECTED_ROWS[i].targets;
            send_tick(tgt, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].result);
         end
      end

      goal = motor_pos;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin sender_idle_pct = 34; receiver_stall_pct = 88; end
            1: begin sender_idle_pct = 88; receiver_stall_pct = 34; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         for (int s = 0; s < SEGMENTS; s++) begin
            r = $urandom_range(9);
            set_hold_ticks(r == 0 ? 8'd0 : r == 1 ? 8'd255 : 8'($urandom_range(1, 8)));
            repeat (SEG_ITEMS) begin
               for (int m = 0; m < MOTOR_COUNT; m++) begin
                  // Goals mostly sit a short move away so moves finish and stop.
                  if ($urandom_range(99) < 8) begin
                     r = $urandom_range(99);
                     if (r < 70) begin
                        v = int'(motor_pos[m]) + int'($urandom_range(24)) - 12;
                        v = v < 0 ? 0 : v > 65535 ? 65535 : v;
                        goal[m] = v[POS_W-1:0];
                     end else if (r < 85) begin
                        goal[m] = motor_pos[m];
                     end else begin
                        goal[m] = POS_W'($urandom);
                     end
                  end
                  tgt[m] = goal[m];
                  // one-off noise target
                  if ($urandom_range(99) < 4)
                     tgt[m] = POS_W'($urandom);
               end
               send_tick(tgt, 1'b0, '0);
            end
         end
      end

      wait_for_idle();
      repeat (4) @(posedge clock);
      if (pending_ticks.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_ticks.size()));
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
